### hw/rtl/mvcd_pkg.sv
package mvcd_pkg;

	localparam int WINDOW_BITS = 24;
	localparam int CODE_BITS   = 12;
	localparam int MAG_COUNT   = 32;
	localparam int RES_MAX     = 6;

	localparam logic [0:0] REG_FCODE = 1'b0;

	typedef struct packed {
		logic [WINDOW_BITS-1:0] bit_window;
		logic signed [11:0]     predictor;
	} item_t;

	typedef struct packed {
		logic signed [11:0] vector_value;
		logic [4:0]         bits_used;
		logic               invalid_code;
	} result_t;

	typedef logic [MAG_COUNT:1][CODE_BITS:0] bound_t;

	typedef struct packed {
		logic [WINDOW_BITS-1:0] bit_window;
		logic signed [11:0]     predictor;
		logic                   zero_flag;
		logic                   invalid;
		logic [MAG_COUNT:1]     below_end;
		logic [MAG_COUNT:1]     at_mid;
	} s1_t;

	typedef struct packed {
		logic [WINDOW_BITS-1:0] bit_window;
		logic signed [11:0]     predictor;
		logic                   invalid;
		logic                   nonzero;
		logic                   neg;
		logic [5:0]             mag;
		logic [4:0]             used;
	} s2_t;

	typedef struct packed {
		logic signed [11:0] predictor;
		logic signed [12:0] mvd;
		logic [4:0]         used;
		logic               invalid;
	} s3_t;

	// code length after the leading zero for magnitude 1..32
	function automatic logic [3:0] mag_len(input logic [5:0] m);
		logic [3:0] len;
		priority if (m <= 6'd1) len = 4'd2;
		else if (m <= 6'd2) len = 4'd3;
		else if (m <= 6'd3) len = 4'd4;
		else if (m <= 6'd4) len = 4'd6;
		else if (m <= 6'd7) len = 4'd7;
		else if (m <= 6'd10) len = 4'd9;
		else if (m <= 6'd24) len = 4'd10;
		else if (m <= 6'd30) len = 4'd11;
		else len = 4'd12;
		return len;
	endfunction

	// first code past the negative range of each magnitude
	function automatic bound_t mvd_end_table();
		bound_t t;
		logic [CODE_BITS:0] pos;
		pos = 13'd4;
		t = '0;
		for (int m = MAG_COUNT; m >= 1; m--) begin
			pos = pos + (13'd2 << (4'd12 - mag_len(6'(m))));
			t[m] = pos;
		end
		return t;
	endfunction

	// first code of the negative range of each magnitude
	function automatic bound_t mvd_mid_table();
		bound_t t;
		logic [CODE_BITS:0] pos;
		pos = 13'd4;
		t = '0;
		for (int m = MAG_COUNT; m >= 1; m--) begin
			t[m] = pos + (13'd1 << (4'd12 - mag_len(6'(m))));
			pos = pos + (13'd2 << (4'd12 - mag_len(6'(m))));
		end
		return t;
	endfunction

endpackage

### hw/rtl/mvcd_match.sv
module mvcd_match import mvcd_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  item_t d,
	output s1_t   q_s1
);

	localparam bound_t EndTbl = mvd_end_table();
	localparam bound_t MidTbl = mvd_mid_table();

	logic [CODE_BITS-1:0] code;
	s1_t                  nxt;

	assign code = d.bit_window[WINDOW_BITS-2 -: CODE_BITS];

	always_comb begin
		nxt.bit_window = d.bit_window;
		nxt.predictor  = d.predictor;
		nxt.zero_flag  = d.bit_window[WINDOW_BITS-1];
		nxt.invalid    = !d.bit_window[WINDOW_BITS-1] && (code < 12'd4);
		for (int m = 1; m <= MAG_COUNT; m++) begin
			nxt.below_end[m] = {1'b0, code} < EndTbl[m];
			nxt.at_mid[m]    = {1'b0, code} >= MidTbl[m];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1 <= nxt;
		end
	end

endmodule

### hw/rtl/mvcd_select.sv
module mvcd_select import mvcd_pkg::*; (
	input  logic clk,
	input  logic en,
	input  s1_t  d_s1,
	output s2_t  q_s2
);

	s2_t        nxt;
	logic [5:0] mag;
	logic       neg;

	// highest magnitude whose range still ends above the code
	always_comb begin
		mag = 6'd0;
		neg = 1'b0;
		for (int m = 1; m <= MAG_COUNT; m++) begin
			if (d_s1.below_end[m]) begin
				mag = 6'(m);
				neg = d_s1.at_mid[m];
			end
		end
	end

	always_comb begin
		nxt.bit_window = d_s1.bit_window;
		nxt.predictor  = d_s1.predictor;
		nxt.invalid    = d_s1.invalid;
		nxt.nonzero    = !d_s1.zero_flag && !d_s1.invalid;
		nxt.neg        = neg;
		nxt.mag        = mag;
		nxt.used       = nxt.nonzero ? 5'd1 + {1'b0, mag_len(mag)} : 5'd1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s2 <= nxt;
		end
	end

endmodule

### hw/rtl/mvcd_scale.sv
module mvcd_scale import mvcd_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  logic [2:0] fc_m1,
	input  s2_t        d_s2,
	output s3_t        q_s3
);

	logic [WINDOW_BITS-1:0] aligned;
	logic [RES_MAX-1:0]     res;
	logic [12:0]            mag_mvd;
	s3_t                    nxt;

	always_comb begin
		aligned = d_s2.bit_window << d_s2.used;
		res     = aligned[WINDOW_BITS-1 -: RES_MAX] >> (3'd6 - fc_m1);
		mag_mvd = ({7'd0, d_s2.mag - 6'd1} << fc_m1) + {7'd0, res} + 13'd1;

		nxt.predictor = d_s2.predictor;
		nxt.invalid   = d_s2.invalid;
		if (!d_s2.nonzero) begin
			nxt.mvd  = '0;
			nxt.used = d_s2.used;
		end else begin
			nxt.mvd  = d_s2.neg ? -$signed(mag_mvd) : $signed(mag_mvd);
			nxt.used = d_s2.used + {2'b00, fc_m1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s3 <= nxt;
		end
	end

endmodule

### hw/rtl/mvcd_recon.sv
module mvcd_recon import mvcd_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  logic [2:0] fc_m1,
	input  s3_t        d_s3,
	output result_t    q_s4
);

	logic signed [13:0] half_range;
	logic signed [13:0] lo_bound;
	logic signed [13:0] hi_bound;
	logic signed [13:0] sum_a;
	logic signed [13:0] sum_b;
	logic signed [13:0] sum_c;
	result_t            nxt;

	// wrap once into [-32*scale, 32*scale-1]
	always_comb begin
		half_range = $signed(14'd32 << fc_m1);
		lo_bound   = -half_range;
		hi_bound   = half_range - 14'sd1;
		sum_a      = 14'(d_s3.predictor) + 14'(d_s3.mvd);
		sum_b      = (sum_a < lo_bound) ? sum_a + (half_range <<< 1) : sum_a;
		sum_c      = (sum_b > hi_bound) ? sum_b - (half_range <<< 1) : sum_b;

		nxt.vector_value = sum_c[11:0];
		nxt.bits_used    = d_s3.used;
		nxt.invalid_code = d_s3.invalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s4 <= nxt;
		end
	end

endmodule

### hw/rtl/motion_vector_component_decode_unit.sv
// Decodes one motion vector component per beat: the top bit of bit_window
// (MSB first) and the following 12-bit VLC code give the difference, an
// fcode-1 bit residual follows when fcode exceeds 1, and the scaled
// difference plus predictor is wrapped into the fcode range. The block is a
// four-stage pipeline (code compare, magnitude select, residual and scale,
// add and wrap): a result is offered from the add and wrap stage register
// once its item has passed every stage, and one item is taken every cycle while
// the output side keeps up. Each stage holds its beat under stall and empty
// stages still fill. The fcode register sits at byte address 0 of the APB
// port; fcode 0 acts as 1.
module motion_vector_component_decode_unit import mvcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,

	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [2:0] fcode_q;
	logic [2:0] fc_m1;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4;

	s1_t     pipe_s1;
	s2_t     pipe_s2;
	s3_t     pipe_s3;
	result_t pipe_s4;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FCODE) ? {29'd0, fcode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcode_q <= 3'd1;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_FCODE) begin
			fcode_q <= pwdata[2:0];
		end
	end

	assign fc_m1 = (fcode_q == 3'd0) ? 3'd0 : fcode_q - 3'd1;

	// a stage takes a new beat when empty or when its own beat moves on
	assign ready_s4 = !valid_s4 || !result_stall;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;

	assign item_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= item_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	mvcd_match u_match (
		.clk  (clk),
		.en   (ready_s1 && item_valid),
		.d    (item),
		.q_s1 (pipe_s1)
	);

	mvcd_select u_select (
		.clk  (clk),
		.en   (ready_s2 && valid_s1),
		.d_s1 (pipe_s1),
		.q_s2 (pipe_s2)
	);

	mvcd_scale u_scale (
		.clk   (clk),
		.en    (ready_s3 && valid_s2),
		.fc_m1 (fc_m1),
		.d_s2  (pipe_s2),
		.q_s3  (pipe_s3)
	);

	mvcd_recon u_recon (
		.clk   (clk),
		.en    (ready_s4 && valid_s3),
		.fc_m1 (fc_m1),
		.d_s3  (pipe_s3),
		.q_s4  (pipe_s4)
	);

	assign result_valid = valid_s4;
	assign result       = pipe_s4;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall == (valid_s1 && valid_s2 && valid_s3 && valid_s4 && result_stall))
		else $error("input stall does not match a full stalled pipeline");

	a_invalid_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.invalid_code |-> result.bits_used == 5'd1)
		else $error("invalid code consumed more than the leading bit");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.bits_used >= 5'd1 && result.bits_used <= 5'd19)
		else $error("bits_used out of range");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !valid_s4 |=> valid_s4)
		else $error("beat lost between stage three and the output");

endmodule
